### rtl/breakpoint_envelope_table_defines.svh
// Assertion macros for the breakpoint envelope table.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef BREAKPOINT_ENVELOPE_TABLE_DEFINES_SVH
`define BREAKPOINT_ENVELOPE_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define BET_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define BET_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define BET_ASSERT(lbl, prop, msg)
`define BET_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### rtl/bet_pkg.sv
// Shared types and constants of the breakpoint envelope table.
// No dependencies.
`timescale 1ns / 1ps
package bet_pkg;
    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    typedef enum logic [1:0] {
        CMD_UPSERT = 2'd0,
        CMD_ERASE  = 2'd1,
        CMD_MOVE   = 2'd2,
        CMD_QUERY  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_CLOSED   = 3'd1,
        ST_BAD      = 3'd2,
        ST_PAST     = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_OCCUPIED = 3'd5,
        ST_FULL     = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        CFG_EDIT_EN = 3'd0,
        CFG_MIN     = 3'd1,
        CFG_MAX     = 3'd2,
        CFG_NEUTRAL = 3'd3,
        CFG_REGION  = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OP_HOLD = 2'd0,
        OP_INS  = 2'd1,
        OP_DEL  = 2'd2,
        OP_SET  = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cmd               cmd;
        logic signed [31:0] tick;
        logic signed [15:0] amount;
        logic signed [31:0] from_tick;
    } t_in_beat;

    typedef struct packed {
        t_status            status;
        logic signed [15:0] value;
        logic [6:0]         point_count;
    } t_out_beat;

    typedef struct packed {
        logic [30:0]        tick;
        logic signed [15:0] amt;
    } t_point;

    typedef struct packed {
        t_cell_op           op;
        logic signed [31:0] key;
        logic signed [15:0] amt;
    } t_cell_ctrl;
endpackage

### rtl/breakpoint_envelope_table.sv
// Top level of the breakpoint envelope table: command sequencer, config registers,
// the row of bet_cell slots and the bet_div divider. Depends on bet_pkg.
`timescale 1ns / 1ps
`include "breakpoint_envelope_table_defines.svh"
// Holds up to MAX_POINTS breakpoints sorted by tick in a row of cells; every cell
// compares itself with a broadcast key, and the cells at or above the key shift
// one place on insert or erase. One command at a time; a query that falls between
// two points interpolates through the bit-serial divider. The input is ready again
// once the result is loaded. A result waits in the output register while the next
// beat is taken, and an output stall holds a finished beat until the register is
// free. Config writes are always ready and take effect at once.
module breakpoint_envelope_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bet_pkg::t_in_beat  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bet_pkg::t_out_beat o_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [30:0]        i_cfg_data
);
    localparam int N = bet_pkg::MAX_POINTS;

    typedef enum logic [2:0] {
        S_IDLE, S_LOOK, S_LOOK_FROM, S_INS, S_MUL, S_DIV, S_OUT
    } t_state;

    t_state r_state;
    logic r_out_valid;
    bet_pkg::t_out_beat r_out;

    logic               r_en;
    logic signed [15:0] r_min, r_max, r_neutral;
    logic [30:0]        r_region;

    bet_pkg::t_cmd       r_cmd;
    logic signed [31:0]  r_tick, r_from, r_key;
    logic signed [15:0]  r_amt;
    bet_pkg::t_status    r_status;
    logic signed [15:0]  r_value;
    logic                r_occ;
    logic [bet_pkg::CNT_W-1:0] r_count;

    logic [30:0]        r_diff, r_span;
    logic signed [15:0] r_a0;
    logic               r_neg;
    logic [15:0]        r_dmag;
    logic [46:0]        r_prod;
    logic               r_div_start;
    logic               w_div_done;
    logic [15:0]        w_quo;

    bet_pkg::t_cell_ctrl w_ctrl;
    bet_pkg::t_point     w_pt [N];
    logic [N-1:0] w_valid, w_lt, w_eq, w_b, w_last;
    logic w_hit, w_full, w_any_b, w_bad, w_past;
    logic w_emit;
    logic [30:0]        w_t0, w_t1;
    logic signed [15:0] w_a0, w_a1, w_alast;
    logic signed [16:0] w_d, w_res;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_cell
            bet_pkg::t_point w_left, w_right;
            logic w_left_lt;
            assign w_valid[k] = (bet_pkg::CNT_W'(k) < r_count);
            if (k == 0) begin : g_first
                assign w_left    = '0;
                assign w_left_lt = 1'b1;
            end else begin : g_mid
                assign w_left    = w_pt[k-1];
                assign w_left_lt = w_lt[k-1];
            end
            if (k == N - 1) begin : g_end
                assign w_right = '0;
                assign w_last[k] = w_valid[k];
            end else begin : g_nend
                assign w_right = w_pt[k+1];
                assign w_last[k] = w_valid[k] && !w_valid[k+1];
            end
            // first slot whose tick is not below the key
            assign w_b[k] = w_valid[k] && !w_lt[k] && w_left_lt;
            bet_cell u_cell (
                .i_clk     (i_clk),
                .i_ctrl    (w_ctrl),
                .i_valid   (w_valid[k]),
                .i_left    (w_left),
                .i_left_lt (w_left_lt),
                .i_right   (w_right),
                .o_point   (w_pt[k]),
                .o_lt      (w_lt[k]),
                .o_eq      (w_eq[k])
            );
        end
    endgenerate

    assign w_hit   = |w_eq;
    assign w_any_b = |w_b;
    assign w_full  = (r_count >= bet_pkg::CNT_W'(N));

    always_comb begin
        w_t0 = '0; w_t1 = '0; w_a0 = '0; w_a1 = '0; w_alast = '0;
        for (int j = 0; j < N; j++) begin
            w_t1    = w_t1 | ({31{w_b[j]}} & w_pt[j].tick);
            w_a1    = w_a1 | ({16{w_b[j]}} & w_pt[j].amt);
            w_alast = w_alast | ({16{w_last[j]}} & w_pt[j].amt);
            if (j < N - 1) begin
                w_t0 = w_t0 | ({31{w_b[j+1]}} & w_pt[j].tick);
                w_a0 = w_a0 | ({16{w_b[j+1]}} & w_pt[j].amt);
            end
        end
    end
    assign w_d   = 17'(w_a1) - 17'(w_a0);
    assign w_res = r_neg ? (17'(r_a0) - 17'({1'b0, w_quo}))
                         : (17'(r_a0) + 17'({1'b0, w_quo}));

    assign w_bad  = (i_in.tick < 0) || (i_in.amount < r_min) || (i_in.amount > r_max);
    assign w_past = (i_in.tick > $signed({1'b0, r_region}));

    // load the finished beat once the output register is free
    assign w_emit = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    always_comb begin
        w_ctrl.key = r_key;
        w_ctrl.amt = r_amt;
        w_ctrl.op  = bet_pkg::OP_HOLD;
        case (r_state)
            S_LOOK: begin
                if (r_cmd == bet_pkg::CMD_ERASE && w_hit) w_ctrl.op = bet_pkg::OP_DEL;
                else if (r_cmd == bet_pkg::CMD_UPSERT && w_hit) w_ctrl.op = bet_pkg::OP_SET;
                else if (r_cmd == bet_pkg::CMD_UPSERT && !w_full) w_ctrl.op = bet_pkg::OP_INS;
            end
            S_LOOK_FROM: begin
                if (w_hit && !(r_from != r_tick && r_occ)) w_ctrl.op = bet_pkg::OP_DEL;
            end
            S_INS:   w_ctrl.op = bet_pkg::OP_INS;
            default: w_ctrl.op = bet_pkg::OP_HOLD;
        endcase
    end

    bet_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_prod),
        .i_den   (r_span),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en        <= 1'b1;
            r_min       <= -16'sd6144;
            r_max       <= 16'sd6144;
            r_neutral   <= '0;
            r_region    <= 31'h7FFF_FFFF;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bet_pkg::CFG_EDIT_EN: r_en      <= i_cfg_data[0];
                bet_pkg::CFG_MIN:     r_min     <= i_cfg_data[15:0];
                bet_pkg::CFG_MAX:     r_max     <= i_cfg_data[15:0];
                bet_pkg::CFG_NEUTRAL: r_neutral <= i_cfg_data[15:0];
                bet_pkg::CFG_REGION:  r_region  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= (r_state == S_MUL);
            if (w_emit) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
            if (w_ctrl.op == bet_pkg::OP_INS) r_count <= r_count + 1'b1;
            else if (w_ctrl.op == bet_pkg::OP_DEL) r_count <= r_count - 1'b1;
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd    <= i_in.cmd;
                        r_tick   <= i_in.tick;
                        r_key    <= i_in.tick;
                        r_amt    <= i_in.amount;
                        r_from   <= i_in.from_tick;
                        r_value  <= '0;
                        if (i_in.cmd != bet_pkg::CMD_QUERY && !r_en) begin
                            r_status <= bet_pkg::ST_CLOSED;
                            r_state  <= S_OUT;
                        end else if ((i_in.cmd == bet_pkg::CMD_UPSERT ||
                                      i_in.cmd == bet_pkg::CMD_MOVE) && w_bad) begin
                            r_status <= bet_pkg::ST_BAD;
                            r_state  <= S_OUT;
                        end else if ((i_in.cmd == bet_pkg::CMD_UPSERT ||
                                      i_in.cmd == bet_pkg::CMD_MOVE) && w_past) begin
                            r_status <= bet_pkg::ST_PAST;
                            r_state  <= S_OUT;
                        end else begin
                            r_status <= bet_pkg::ST_OK;
                            r_state  <= S_LOOK;
                        end
                    end
                end
                S_LOOK: begin
                    case (r_cmd)
                        bet_pkg::CMD_QUERY: begin
                            if (r_count == '0) begin
                                r_value <= r_neutral;
                                r_state <= S_OUT;
                            end else if (!w_any_b) begin
                                r_value <= w_alast;
                                r_state <= S_OUT;
                            end else if (w_b[0] || w_hit) begin
                                r_value <= w_a1;
                                r_state <= S_OUT;
                            end else begin
                                r_diff  <= 31'(r_tick - $signed({1'b0, w_t0}));
                                r_span  <= w_t1 - w_t0;
                                r_a0    <= w_a0;
                                r_neg   <= w_d[16];
                                r_dmag  <= 16'(w_d[16] ? -w_d : w_d);
                                r_state <= S_MUL;
                            end
                        end
                        bet_pkg::CMD_ERASE: begin
                            if (!w_hit) r_status <= bet_pkg::ST_NOTFOUND;
                            r_state <= S_OUT;
                        end
                        bet_pkg::CMD_UPSERT: begin
                            if (!w_hit && w_full) r_status <= bet_pkg::ST_FULL;
                            r_state <= S_OUT;
                        end
                        default: begin
                            r_occ   <= w_hit;
                            r_key   <= r_from;
                            r_state <= S_LOOK_FROM;
                        end
                    endcase
                end
                S_LOOK_FROM: begin
                    if (!w_hit) begin
                        r_status <= bet_pkg::ST_NOTFOUND;
                        r_state  <= S_OUT;
                    end else if (r_from != r_tick && r_occ) begin
                        r_status <= bet_pkg::ST_OCCUPIED;
                        r_state  <= S_OUT;
                    end else begin
                        r_key   <= r_tick;
                        r_state <= S_INS;
                    end
                end
                S_INS: r_state <= S_OUT;
                S_MUL: begin
                    r_prod  <= 47'(r_dmag) * 47'(r_diff);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_value <= w_res[15:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hold the finished beat until the output register is free
                    if (w_emit) begin
                        r_out.status      <= r_status;
                        r_out.value       <= r_value;
                        r_out.point_count <= 7'(r_count);
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `BET_ASSERT(a_count_max, (r_count <= bet_pkg::CNT_W'(N)), "point count above capacity")
    `BET_ASSERT(a_count_step, (8'(r_count) + 8'd1 - 8'($past(r_count)) <= 8'd2), "count jumped")
    `BET_ASSERT(a_busy_after_accept, ((i_in_valid && o_in_ready) |=> !o_in_ready), "beat taken while busy")
    `BET_ASSERT(a_div_done_state, (w_div_done |-> (r_state == S_DIV)), "divider done outside S_DIV")
endmodule

### rtl/bet_cell.sv
// One slot of the sorted breakpoint row: holds a point, compares it to the key,
// and shifts toward either neighbor. Depends on bet_pkg.
`timescale 1ns / 1ps
module bet_cell (
    input  logic                i_clk,
    input  bet_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_valid,
    input  bet_pkg::t_point     i_left,
    input  logic                i_left_lt,
    input  bet_pkg::t_point     i_right,
    output bet_pkg::t_point     o_point,
    output logic                o_lt,
    output logic                o_eq
);
    bet_pkg::t_point r_pt;
    bet_pkg::t_point n_pt;
    logic signed [31:0] w_tick;

    assign w_tick  = $signed({1'b0, r_pt.tick});
    assign o_lt    = i_valid && (w_tick < i_ctrl.key);
    assign o_eq    = i_valid && (w_tick == i_ctrl.key);
    assign o_point = r_pt;

    always_comb begin
        n_pt = r_pt;
        case (i_ctrl.op)
            bet_pkg::OP_INS: begin
                if (!o_lt) begin
                    if (i_left_lt) begin
                        n_pt.tick = i_ctrl.key[30:0];
                        n_pt.amt  = i_ctrl.amt;
                    end else begin
                        n_pt = i_left;
                    end
                end
            end
            bet_pkg::OP_DEL: begin
                if (!o_lt) n_pt = i_right;
            end
            bet_pkg::OP_SET: begin
                if (o_eq) n_pt.amt = i_ctrl.amt;
            end
            default: n_pt = r_pt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_pt <= n_pt;
    end
endmodule

### rtl/bet_div.sv
// Restoring divider, one quotient bit per cycle, for the interpolation step.
// Depends on nothing but the clock and reset.
`timescale 1ns / 1ps
module bet_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [46:0] i_num,
    input  logic [30:0] i_den,
    output logic        o_done,
    output logic [15:0] o_quo
);
    logic [30:0] r_rem;
    logic [15:0] r_lo;
    logic [15:0] r_quo;
    logic [30:0] r_den;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [31:0] w_trial;
    logic        w_fit;

    assign w_trial = {r_rem, r_lo[15]};
    assign w_fit   = w_trial >= {1'b0, r_den};
    assign o_done  = r_done;
    assign o_quo   = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= i_num[46:16];
                r_lo   <= i_num[15:0];
                r_den  <= i_den;
                r_cnt  <= 5'd16;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                // quotient stays below 2^16, so the remainder fits 31 bits
                r_rem <= w_fit ? 31'(w_trial - {1'b0, r_den}) : w_trial[30:0];
                r_lo  <= {r_lo[14:0], 1'b0};
                r_quo <= {r_quo[14:0], w_fit};
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

### dv/tb_breakpoint_envelope_table.sv
// Self-checking testbench for the breakpoint envelope table: directed and random
// commands with random stalls, checked against a behavioral table model.
// Depends on bet_pkg and the breakpoint_envelope_table RTL.
`timescale 1ns / 1ps
module tb_breakpoint_envelope_table;
    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    bet_pkg::t_in_beat   i_in;
    logic                o_out_valid;
    logic                i_out_ready;
    bet_pkg::t_out_beat  o_out;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [2:0]          i_cfg_index;
    logic [30:0]         i_cfg_data;

    breakpoint_envelope_table i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Table model
    longint    tbl_tick [bet_pkg::MAX_POINTS];
    int        tbl_amt  [bet_pkg::MAX_POINTS];
    int        tbl_count;
    bit        edit_en;
    int        amt_lo, amt_hi, amt_neutral;
    longint    region_len;

    bet_pkg::t_in_beat  cmd_queue [$];
    bet_pkg::t_out_beat result_queue [$];
    int        pending_cmds;
    int        fail_count;
    bit        driver_hold;
    int        in_gap, out_gap;

    function automatic int lower_slot(longint t);
        int i;
        i = 0;
        while (i < tbl_count && tbl_tick[i] < t) i++;
        return i;
    endfunction

    function automatic bit has_point(longint t);
        int i;
        i = lower_slot(t);
        return i < tbl_count && tbl_tick[i] == t;
    endfunction

    function automatic void drop_slot(int i);
        for (int k = i; k + 1 < tbl_count; k++) begin
            tbl_tick[k] = tbl_tick[k + 1];
            tbl_amt[k]  = tbl_amt[k + 1];
        end
        tbl_count--;
    endfunction

    function automatic void add_slot(int i, longint t, int a);
        for (int k = tbl_count; k > i; k--) begin
            tbl_tick[k] = tbl_tick[k - 1];
            tbl_amt[k]  = tbl_amt[k - 1];
        end
        tbl_tick[i] = t;
        tbl_amt[i]  = a;
        tbl_count++;
    endfunction

    function automatic int envelope_at(longint t);
        int i;
        longint t0, t1, a0, a1;
        if (tbl_count == 0) return amt_neutral;
        i = lower_slot(t);
        if (i == 0) return tbl_amt[0];
        if (i >= tbl_count) return tbl_amt[tbl_count - 1];
        if (tbl_tick[i] == t) return tbl_amt[i];
        t0 = tbl_tick[i - 1];
        t1 = tbl_tick[i];
        a0 = tbl_amt[i - 1];
        a1 = tbl_amt[i];
        return int'(a0 + ((a1 - a0) * (t - t0)) / (t1 - t0));
    endfunction

    function automatic bet_pkg::t_status check_dest(longint t, int a);
        if (t < 0 || a < amt_lo || a > amt_hi) return bet_pkg::ST_BAD;
        if (t > region_len) return bet_pkg::ST_PAST;
        return bet_pkg::ST_OK;
    endfunction

    function automatic bet_pkg::t_out_beat apply_command(bet_pkg::t_in_beat c);
        bet_pkg::t_out_beat r;
        longint    t, from;
        int        a, at;
        t    = longint'(c.tick);
        from = longint'(c.from_tick);
        a    = int'(c.amount);
        r.status = bet_pkg::ST_OK;
        r.value  = '0;
        if (c.cmd == bet_pkg::CMD_QUERY) begin
            r.value = 16'(envelope_at(t));
        end else if (!edit_en) begin
            r.status = bet_pkg::ST_CLOSED;
        end else if (c.cmd == bet_pkg::CMD_ERASE) begin
            if (has_point(t)) drop_slot(lower_slot(t));
            else r.status = bet_pkg::ST_NOTFOUND;
        end else begin
            r.status = check_dest(t, a);
            if (r.status == bet_pkg::ST_OK && c.cmd == bet_pkg::CMD_UPSERT) begin
                at = lower_slot(t);
                if (has_point(t)) tbl_amt[at] = a;
                else if (tbl_count >= bet_pkg::MAX_POINTS) r.status = bet_pkg::ST_FULL;
                else add_slot(at, t, a);
            end else if (r.status == bet_pkg::ST_OK) begin
                if (!has_point(from)) r.status = bet_pkg::ST_NOTFOUND;
                else if (from != t && has_point(t)) r.status = bet_pkg::ST_OCCUPIED;
                else begin
                    drop_slot(lower_slot(from));
                    add_slot(lower_slot(t), t, a);
                end
            end
        end
        r.point_count = 7'(tbl_count);
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Driver: one beat at a time from the command queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap     <= 0;
        end else if (i_in_valid && !o_in_ready) begin
            // hold the beat
        end else begin
            if (i_in_valid) begin
                result_queue.insert(result_queue.size(), apply_command(i_in));
                pending_cmds <= pending_cmds - 1;
            end
            if (in_gap > 0) begin
                in_gap     <= in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (cmd_queue.size() > 0 && !driver_hold) begin
                i_in       <= cmd_queue.pop_front();
                i_in_valid <= 1'b1;
                in_gap     <= pick_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor and sink stalls
    always @(posedge i_clk) begin
        bet_pkg::t_out_beat exp_beat;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_gap     <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (result_queue.size() == 0) begin
                    $error("result beat with nothing expected");
                    fail_count++;
                end else begin
                    exp_beat = result_queue.pop_front();
                    if (o_out.status !== exp_beat.status) begin
                        $error("status: expected %0d, got %0d", exp_beat.status, o_out.status);
                        fail_count++;
                    end
                    if (o_out.value !== exp_beat.value) begin
                        $error("value: expected %0d, got %0d", exp_beat.value, o_out.value);
                        fail_count++;
                    end
                    if (o_out.point_count !== exp_beat.point_count) begin
                        $error("point_count: expected %0d, got %0d",
                               exp_beat.point_count, o_out.point_count);
                        fail_count++;
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap     <= out_gap - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                out_gap     <= pick_gap();
            end
        end
    end

    task automatic send(bet_pkg::t_cmd c, longint t, int a, longint f);
        bet_pkg::t_in_beat b;
        b.cmd       = c;
        b.tick      = 32'(t);
        b.amount    = 16'(a);
        b.from_tick = 32'(f);
        cmd_queue.insert(cmd_queue.size(), b);
        pending_cmds++;
    endtask

    task automatic drain();
        while (pending_cmds > 0 || result_queue.size() > 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_reg(bet_pkg::t_cfg_idx idx, int data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= 31'(data);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            bet_pkg::CFG_EDIT_EN: edit_en     = data[0];
            bet_pkg::CFG_MIN:     amt_lo      = int'($signed(16'(data)));
            bet_pkg::CFG_MAX:     amt_hi      = int'($signed(16'(data)));
            bet_pkg::CFG_NEUTRAL: amt_neutral = int'($signed(16'(data)));
            bet_pkg::CFG_REGION:  region_len  = longint'(data & 32'h7fff_ffff);
            default: ;
        endcase
    endtask

    // Ticks drawn from a small span so edits collide, with some noise
    task automatic random_phase(int n, int tick_span);
        longint        t, f;
        int            a, p;
        bet_pkg::t_cmd c;
        for (int k = 0; k < n; k++) begin
            p = $urandom_range(0, 99);
            c = bet_pkg::t_cmd'($urandom_range(0, 3));
            t = $urandom_range(0, tick_span);
            f = $urandom_range(0, tick_span);
            a = $urandom_range(0, 12288) - 6144;
            if (p < 6) t = longint'($signed(32'($urandom())));
            if (p >= 6 && p < 12) f = longint'($signed(32'($urandom())));
            if (p >= 12 && p < 18) a = int'($signed(16'($urandom())));
            send(c, t, a, f);
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in         = '0;
        i_out_ready  = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = bet_pkg::CFG_EDIT_EN;
        i_cfg_data   = '0;
        pending_cmds = 0;
        fail_count   = 0;
        driver_hold  = 1'b0;
        tbl_count    = 0;
        edit_en      = 1'b1;
        amt_lo       = -6144;
        amt_hi       = 6144;
        amt_neutral  = 0;
        region_len   = 64'h7fff_ffff;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty query, ends, interpolation, bad, not-found and occupied statuses
        send(bet_pkg::CMD_QUERY, 5, 0, 0);
        send(bet_pkg::CMD_UPSERT, 0, -6144, 0);
        send(bet_pkg::CMD_UPSERT, 2147483647, 6144, 0);
        send(bet_pkg::CMD_UPSERT, 100, 256, 0);
        send(bet_pkg::CMD_UPSERT, 100, -256, 0);
        send(bet_pkg::CMD_QUERY, -2147483648, 0, 0);
        send(bet_pkg::CMD_QUERY, 50, 0, 0);
        send(bet_pkg::CMD_QUERY, 1073741823, 0, 0);
        send(bet_pkg::CMD_QUERY, 2147483647, 0, 0);
        send(bet_pkg::CMD_UPSERT, -1, 0, 0);
        send(bet_pkg::CMD_UPSERT, 10, 6145, 0);
        send(bet_pkg::CMD_UPSERT, 10, -32768, 0);
        send(bet_pkg::CMD_ERASE, -5, 0, 0);
        send(bet_pkg::CMD_ERASE, 100, 0, 0);
        send(bet_pkg::CMD_MOVE, 20, 32, 77);
        send(bet_pkg::CMD_MOVE, 0, 32, 2147483647);
        send(bet_pkg::CMD_MOVE, 0, 512, 0);
        send(bet_pkg::CMD_MOVE, 300, 100, 0);
        send(bet_pkg::CMD_QUERY, 150, 0, -1);
        drain();

        // Closed table, inverted bounds, short region, neutral at extreme
        write_reg(bet_pkg::CFG_EDIT_EN, 0);
        write_reg(bet_pkg::CFG_NEUTRAL, 16'h8000);
        send(bet_pkg::CMD_UPSERT, 7, 0, 0);
        send(bet_pkg::CMD_ERASE, 300, 0, 0);
        send(bet_pkg::CMD_MOVE, 8, 0, 300);
        send(bet_pkg::CMD_QUERY, 200, 0, 0);
        drain();
        write_reg(bet_pkg::CFG_EDIT_EN, 1);
        write_reg(bet_pkg::CFG_MIN, 100);
        write_reg(bet_pkg::CFG_MAX, -100);
        write_reg(bet_pkg::CFG_REGION, 1000);
        send(bet_pkg::CMD_UPSERT, 7, 0, 0);
        drain();
        write_reg(bet_pkg::CFG_MIN, 16'h8000);
        write_reg(bet_pkg::CFG_MAX, 16'h7fff);
        send(bet_pkg::CMD_UPSERT, 1001, 0, 0);
        send(bet_pkg::CMD_UPSERT, 1000, 32767, 0);
        send(bet_pkg::CMD_UPSERT, 999, -32768, 0);
        send(bet_pkg::CMD_QUERY, 999, 0, 0);
        random_phase(120, 1200);
        drain();

        // Fill to capacity, hitting the full status
        write_reg(bet_pkg::CFG_REGION, 31'h7fff_ffff);
        for (int k = 0; k < 70; k++)
            send(bet_pkg::CMD_UPSERT, 5000 + k * 37, $urandom_range(0, 65535) - 32768, 0);
        send(bet_pkg::CMD_QUERY, 5100, 0, 0);
        driver_hold = 1'b1;
        repeat (3) @(posedge i_clk);
        driver_hold = 1'b0;
        drain();

        write_reg(bet_pkg::CFG_NEUTRAL, 16'h7fff);
        write_reg(bet_pkg::CFG_MIN, -6144);
        write_reg(bet_pkg::CFG_MAX, 6144);
        for (int k = 0; k < 70; k++) send(bet_pkg::CMD_ERASE, 5000 + k * 37, 0, 0);
        send(bet_pkg::CMD_QUERY, 1, 0, 0);
        random_phase(120, 80);
        drain();

        write_reg(bet_pkg::CFG_REGION, 0);
        random_phase(40, 4);
        drain();

        if (fail_count == 0) $display("breakpoint_envelope_table regression: pass");
        else $display("breakpoint_envelope_table regression: fail");
        $finish;
    end

    initial begin
        #5ms;
        $display("breakpoint_envelope_table regression: fail");
        $finish;
    end
endmodule
